// File: hw/rtl/tsp_pkg.sv
package tsp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 9;
    localparam int ADDR_W      = 3;

    localparam logic [1:0] STATUS_FOUND    = 2'd0;
    localparam logic [1:0] STATUS_NONE     = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [ADDR_W-3:0] REG_TARGET_SUM = '0;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] first_position;
        logic [POS_W-1:0] second_position;
    } out_beat_t;

    // What travels down the row of cells with each number.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [32:0] need;
        logic [CNT_W-1:0]   pos;
        logic               last;
        logic               hit;
        logic [IDX_W-1:0]   hit_pos;
    } token_t;

endpackage

// File: hw/rtl/tsp_cell.sv
module tsp_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [tsp_pkg::IDX_W-1:0]  cell_idx,
    input  logic                       in_valid,
    input  tsp_pkg::token_t            in_tok,
    output logic                       out_valid,
    output tsp_pkg::token_t            out_tok
);

    logic signed [31:0] stored_reg;
    logic               valid_reg;
    tsp_pkg::token_t    tok_reg;
    tsp_pkg::token_t    tok_next;
    logic               older;
    logic               match;

    // Only a number that came earlier in the same set may pair with this one.
    assign older = tsp_pkg::CNT_W'(cell_idx) < in_tok.pos;
    assign match = in_valid && !in_tok.hit && older &&
                   ({stored_reg[31], stored_reg} == in_tok.need);

    always_comb begin
        tok_next = in_tok;
        if (match) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_pos = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_reg <= tok_next;
            if (in_valid && (in_tok.pos == tsp_pkg::CNT_W'(cell_idx))) begin
                stored_reg <= in_tok.value;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// File: hw/rtl/two_sum_pair_match.sv
// Finds the first pair of numbers in a set that add up to target_sum (full-width
// sum, no wraparound). Numbers enter on s_ at up to one beat per clock and walk a
// row of TABLE_DEPTH cells, one cell per cycle, whenever the row is not stalled;
// the number at position p of a set is kept in cell p, and every later number of
// the set is compared with it as it passes. Beats leave the row in order, and the
// row stalls as a whole while m_ holds a result that is not taken. A beat gives
// at most one result: a pair found (1-based positions of the earliest partner and
// of the current number), a set ended without a pair, or capacity exceeded; once a
// set has answered, its remaining beats give nothing. The table starts empty after
// reset and after every last beat. target_sum sits at APB byte address 0 and must
// be written only while no beat is in the row.
module two_sum_pair_match (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tsp_pkg::in_beat_t           s_beat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tsp_pkg::out_beat_t          m_beat,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic signed [31:0]          target_sum_reg;
    logic [tsp_pkg::CNT_W-1:0]   count_reg;
    logic [tsp_pkg::CNT_W-1:0]   count_next;
    logic                        answered_reg;
    logic                        answered_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    tsp_pkg::out_beat_t          m_beat_reg;
    tsp_pkg::out_beat_t          m_beat_next;
    logic                        advance;
    logic                        s_accept;
    logic                        reg_sel;

    logic                        chain_valid [0:tsp_pkg::TABLE_DEPTH];
    tsp_pkg::token_t             chain_tok   [0:tsp_pkg::TABLE_DEPTH];
    tsp_pkg::token_t             head_tok;
    tsp_pkg::token_t             tail_tok;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_sel = paddr[tsp_pkg::ADDR_W-1:2] == tsp_pkg::REG_TARGET_SUM;
    assign prdata  = reg_sel ? target_sum_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_sum_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            target_sum_reg <= pwdata;
        end
    end

    // The whole row moves together whenever the output register can take a beat.
    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = advance;
    assign s_accept = s_valid && advance;

    always_comb begin
        head_tok.value   = s_beat.value;
        head_tok.need    = {target_sum_reg[31], target_sum_reg} -
                           {s_beat.value[31], s_beat.value};
        head_tok.pos     = count_reg;
        head_tok.last    = s_beat.last;
        head_tok.hit     = 1'b0;
        head_tok.hit_pos = '0;
    end

    assign chain_valid[0] = s_valid;
    assign chain_tok[0]   = head_tok;

    // The count keeps running after a set has answered; those beats are dropped
    // at the tail, so their positions do not matter.
    always_comb begin
        count_next = count_reg;
        if (s_accept) begin
            if (s_beat.last) begin
                count_next = '0;
            end else if (count_reg < tsp_pkg::CNT_W'(tsp_pkg::TABLE_DEPTH)) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar k = 0; k < tsp_pkg::TABLE_DEPTH; k++) begin : g_cell
        tsp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .cell_idx  (tsp_pkg::IDX_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_tok    (chain_tok[k]),
            .out_valid (chain_valid[k+1]),
            .out_tok   (chain_tok[k+1])
        );
    end

    assign tail_tok = chain_tok[tsp_pkg::TABLE_DEPTH];

    // Decide the result of the beat leaving the row.
    always_comb begin
        answered_next = answered_reg;
        m_valid_next  = m_valid_reg;
        m_beat_next   = m_beat_reg;
        if (advance) begin
            m_valid_next                = 1'b0;
            m_beat_next.status          = tsp_pkg::STATUS_NONE;
            m_beat_next.first_position  = '0;
            m_beat_next.second_position = '0;
            if (chain_valid[tsp_pkg::TABLE_DEPTH]) begin
                if (!answered_reg) begin
                    if (tail_tok.hit) begin
                        m_valid_next                = 1'b1;
                        m_beat_next.status          = tsp_pkg::STATUS_FOUND;
                        m_beat_next.first_position  =
                            tsp_pkg::POS_W'(32'(tail_tok.hit_pos) + 32'd1);
                        m_beat_next.second_position =
                            tsp_pkg::POS_W'(32'(tail_tok.pos) + 32'd1);
                        answered_next               = 1'b1;
                    end else if (tail_tok.pos >=
                                 tsp_pkg::CNT_W'(tsp_pkg::TABLE_DEPTH)) begin
                        m_valid_next       = 1'b1;
                        m_beat_next.status = tsp_pkg::STATUS_OVERFLOW;
                        answered_next      = 1'b1;
                    end else if (tail_tok.last) begin
                        m_valid_next       = 1'b1;
                        m_beat_next.status = tsp_pkg::STATUS_NONE;
                    end
                end
                if (tail_tok.last) begin
                    answered_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answered_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            answered_reg <= answered_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_beat_reg <= m_beat_next;
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

`ifndef SYNTHESIS
    a_found_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.status == tsp_pkg::STATUS_FOUND) |->
            (m_beat.first_position < m_beat.second_position &&
             m_beat.first_position != '0))
        else $error("pair positions out of order");

    a_nopair_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.status != tsp_pkg::STATUS_FOUND) |->
            (m_beat.first_position == '0 && m_beat.second_position == '0))
        else $error("positions set on a result without a pair");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tsp_pkg::CNT_W'(tsp_pkg::TABLE_DEPTH))
        else $error("set count beyond table depth");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_beat.last) |=> (count_reg == '0))
        else $error("count not cleared after last beat");
`endif

endmodule
